FILE: src/hdlc_frame_transmitter_core_macros.svh
// ----------------------------------------------------------------------------
// HDLC transmitter assertion macros
// Assertion helpers shared by the RTL; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HDLC_FRAME_TRANSMITTER_CORE_MACROS_SVH
`define HDLC_FRAME_TRANSMITTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that cond holds at every clock edge outside reset.
`define HDLCTX_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("hdlc transmitter check failed");
// Check that cons holds in the cycle after ante.
`define HDLCTX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hdlc transmitter sequence check failed");
`else
`define HDLCTX_ASSERT(label, cond)
`define HDLCTX_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/hdlctx_pkg.sv
// ----------------------------------------------------------------------------
// HDLC transmitter package
// Shared constants, types and helper functions of the HDLC transmitter.
// ----------------------------------------------------------------------------
package hdlctx_pkg;

    localparam int MAX_CLOSING_FLAGS = 4;
    localparam int FLAG_CNT_W        = $clog2(MAX_CLOSING_FLAGS + 1);

    localparam logic [15:0] CRC_POLY     = 16'h8408;
    localparam logic [15:0] CRC_PRESET   = 16'hFFFF;
    localparam logic [7:0]  FLAG_PATTERN = 8'h7E;

    localparam int          CNT_W     = 5;
    localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);
    localparam logic [CNT_W-1:0] FCS_BITS  = CNT_W'(16);

    localparam logic [2:0] STUFF_RUN = 3'd5;

    typedef enum logic [1:0] {
        REQ_DATA   = 2'd0,
        REQ_EOF    = 2'd1,
        REQ_FLAG   = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    // One line bit from the sequencer to the packer.
    typedef struct packed {
        logic valid;
        logic line_bit;
        logic last;
    } t_bit_ev;

    // Sequencer commands to the serial CRC.
    typedef struct packed {
        logic update;
        logic shift;
        logic din;
    } t_crc_ctl;

    // Sequencer status, used for checking.
    typedef struct packed {
        logic       in_flag;
        logic [2:0] ones;
        logic       fcs_end;
    } t_seq_stat;

    // Closing flag count limited to the range 1 .. MAX_CLOSING_FLAGS.
    function automatic logic [FLAG_CNT_W-1:0] clamp_flags(input logic [2:0] fc);
        logic [FLAG_CNT_W-1:0] r;
        if (fc == 3'd0) begin
            r = FLAG_CNT_W'(1);
        end else if (32'(fc) > MAX_CLOSING_FLAGS) begin
            r = FLAG_CNT_W'(MAX_CLOSING_FLAGS);
        end else begin
            r = FLAG_CNT_W'(fc);
        end
        return r;
    endfunction

endpackage

FILE: src/hdlctx_crc.sv
// ----------------------------------------------------------------------------
// HDLC transmitter serial CRC
// Bit-serial reflected CRC-16 that also shifts out the inverted FCS.
// ----------------------------------------------------------------------------
module hdlctx_crc import hdlctx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        fb;

    assign fb = r_crc[0] ^ i_ctl.din;

    always_comb begin
        n_crc = r_crc;
        priority if (i_ctl.update) begin
            n_crc = {1'b0, r_crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end else if (i_ctl.shift) begin
            // Ones shift in, so the register is back at the preset after
            // all sixteen FCS bits have gone out.
            n_crc = {1'b1, r_crc[15:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_PRESET;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

FILE: src/hdlctx_seq.sv
// ----------------------------------------------------------------------------
// HDLC transmitter bit sequencer
// Produces one line bit per cycle while busy and not held by the packer, with zero insertion, FCS and flags.
// ----------------------------------------------------------------------------
module hdlctx_seq import hdlctx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic [2:0] i_flag_count,
    input  logic       i_step_ok,
    input  logic       i_fcs_lsb,
    output t_crc_ctl   o_crc_ctl,
    output t_bit_ev    o_ev,
    output t_seq_stat  o_stat
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DATA = 4'b0010,
        S_FCS  = 4'b0100,
        S_FLAG = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_stuff, n_stuff;
    logic [2:0]            r_ones, n_ones;
    logic [7:0]            r_sh, n_sh;
    logic [FLAG_CNT_W-1:0] r_flags, n_flags;

    logic             fire;
    logic             real_bit;
    logic             out_bit;
    logic [CNT_W-1:0] step_cnt;
    logic [CNT_W-1:0] limit;
    logic [2:0]       step_ones;
    logic             step_stuff;
    logic             seg_end;
    logic             item_last;
    logic             accept;

    assign fire = (r_state != S_IDLE) && i_step_ok;

    always_comb begin
        unique case (r_state)
            S_DATA:  real_bit = r_sh[0];
            S_FCS:   real_bit = ~i_fcs_lsb;
            S_FLAG:  real_bit = FLAG_PATTERN[3'd7 - r_cnt[2:0]];
            default: real_bit = 1'b0;
        endcase
    end

    assign out_bit    = r_stuff ? 1'b0 : real_bit;
    assign step_cnt   = r_stuff ? r_cnt : r_cnt + CNT_W'(1);
    assign step_ones  = out_bit ? r_ones + 3'd1 : 3'd0;
    assign step_stuff = !r_stuff && (r_state != S_FLAG) && (step_ones == STUFF_RUN);
    assign limit      = (r_state == S_FCS) ? FCS_BITS : BYTE_BITS;
    assign seg_end    = (step_cnt == limit) && !step_stuff;
    assign item_last  = seg_end && ((r_state == S_DATA) ||
                        ((r_state == S_FLAG) && (r_flags == FLAG_CNT_W'(1))));

    assign o_ready = (r_state == S_IDLE) || (fire && item_last);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_stuff = r_stuff;
        n_ones  = r_ones;
        n_sh    = r_sh;
        n_flags = r_flags;
        if (fire) begin
            n_cnt   = step_cnt;
            n_ones  = step_ones;
            n_stuff = step_stuff;
            if ((r_state == S_DATA) && !r_stuff) begin
                n_sh = {1'b0, r_sh[7:1]};
            end
            if (seg_end) begin
                n_cnt = '0;
                unique case (r_state)
                    S_DATA: begin
                        n_state = S_IDLE;
                    end
                    S_FCS: begin
                        n_state = S_FLAG;
                    end
                    S_FLAG: begin
                        if (r_flags == FLAG_CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_flags = r_flags - FLAG_CNT_W'(1);
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
        end
        if (accept) begin
            n_cnt = '0;
            unique case (t_req'(i_req_type))
                REQ_DATA: begin
                    n_state = S_DATA;
                    n_sh    = i_data_byte;
                end
                REQ_EOF: begin
                    n_state = S_FCS;
                    n_flags = clamp_flags(i_flag_count);
                end
                REQ_FLAG: begin
                    n_state = S_FLAG;
                    n_flags = FLAG_CNT_W'(1);
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_stuff <= 1'b0;
            r_ones  <= 3'd0;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stuff <= n_stuff;
            r_ones  <= n_ones;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh <= n_sh;
    end

    assign o_crc_ctl.update = fire && (r_state == S_DATA) && !r_stuff;
    assign o_crc_ctl.shift  = fire && (r_state == S_FCS) && !r_stuff;
    assign o_crc_ctl.din    = r_sh[0];

    assign o_ev.valid    = fire;
    assign o_ev.line_bit = out_bit;
    assign o_ev.last     = item_last;

    assign o_stat.in_flag = (r_state == S_FLAG);
    assign o_stat.ones    = r_ones;
    assign o_stat.fcs_end = fire && (r_state == S_FCS) && seg_end;

endmodule

FILE: src/hdlctx_pack.sv
// ----------------------------------------------------------------------------
// HDLC transmitter byte packer
// Gathers line bits into bytes, holds one byte back to mark the last one.
// ----------------------------------------------------------------------------
module hdlctx_pack import hdlctx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bit_ev    i_ev,
    output logic       o_step_ok,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_line_byte,
    output logic       o_last_of_run
);

    logic [6:0] r_shift, n_shift;
    logic [2:0] r_cnt, n_cnt;
    logic       r_pend_valid, n_pend_valid;
    logic       r_pend_final, n_pend_final;
    logic [7:0] r_pend_byte, n_pend_byte;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    logic       can_push;
    logic       completes;
    logic       push_pend;

    assign can_push  = !r_out_valid || i_ready;
    assign o_step_ok = !((r_cnt == 3'd7) && r_pend_valid && !can_push);
    assign completes = i_ev.valid && (r_cnt == 3'd7);
    assign push_pend = r_pend_valid && can_push && (r_pend_final || completes);

    always_comb begin
        n_shift      = r_shift;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_final = r_pend_final;
        n_pend_byte  = r_pend_byte;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;

        if (i_ev.valid) begin
            n_shift = {r_shift[5:0], i_ev.line_bit};
            n_cnt   = r_cnt + 3'd1;
        end

        if (completes) begin
            n_pend_valid = 1'b1;
            n_pend_byte  = {r_shift, i_ev.line_bit};
            n_pend_final = i_ev.last;
        end else if (push_pend) begin
            n_pend_valid = 1'b0;
        end else if (i_ev.valid && i_ev.last && r_pend_valid) begin
            n_pend_final = 1'b1;
        end

        if (push_pend) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_pend_byte;
            n_out_last  = r_pend_final;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= 3'd0;
            r_pend_valid <= 1'b0;
            r_pend_final <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_pend_final <= n_pend_final;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_pend_byte <= n_pend_byte;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_line_byte   = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

FILE: src/hdlc_frame_transmitter_core.sv
// ----------------------------------------------------------------------------
// HDLC frame transmitter core
// Bit-stuffing HDLC framer with CRC-16 FCS, packing line bits into bytes.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Word
//  ---------+---------------------+----------------------------------------
//  request  | i_valid / o_ready   | i_req_type, i_data_byte, i_flag_count
//  line     | o_valid / i_ready   | o_line_byte, o_last_of_run
//
// One line bit goes out per cycle while a request is in progress and the line side does
// not stall; the next request is taken with the last line bit of the current one.
// Reset is synchronous and active low; it presets the CRC and empties the packer.
// A stalled line side fills the output register and one held-back byte, then the
// sequencer pauses on the bit that would complete another byte.
//
module hdlc_frame_transmitter_core import hdlctx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic [2:0] i_flag_count,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_line_byte,
    output logic       o_last_of_run
);

`include "hdlc_frame_transmitter_core_macros.svh"

    t_crc_ctl    crc_ctl;
    t_bit_ev     bit_ev;
    t_seq_stat   seq_stat;
    logic [15:0] crc_val;
    logic        step_ok;
    logic        stuff_due;

    // Serial CRC: updated by each payload bit, shifted out for the FCS.
    hdlctx_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc_val)
    );

    // Sequencer: walks the payload, FCS and flag bits and inserts the
    // stuffed zeros. The run of ones carries across requests.
    hdlctx_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_flag_count (i_flag_count),
        .i_step_ok    (step_ok),
        .i_fcs_lsb    (crc_val[0]),
        .o_crc_ctl    (crc_ctl),
        .o_ev         (bit_ev),
        .o_stat       (seq_stat)
    );

    // Packer: eight line bits to a word. The newest complete word is held
    // back until the next one completes or its request ends, which is how
    // the last word of a request gets its mark.
    hdlctx_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev          (bit_ev),
        .o_step_ok     (step_ok),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_line_byte   (o_line_byte),
        .o_last_of_run (o_last_of_run)
    );

    // A line bit goes out after five ones outside a flag.
    assign stuff_due = bit_ev.valid && !seq_stat.in_flag && (seq_stat.ones == 3'd5);

    // After five ones outside a flag the next line bit is a stuffed zero.
    `HDLCTX_ASSERT(a_stuff_after_five, stuff_due |-> !bit_ev.line_bit)
    // The run of ones on the line never reaches seven.
    `HDLCTX_ASSERT(a_ones_bounded, seq_stat.ones != 3'd7)
    // Shifting out the whole FCS leaves the CRC at its preset.
    `HDLCTX_ASSERT_NEXT(a_crc_preset, seq_stat.fcs_end, crc_val == CRC_PRESET)

endmodule
